/* design/cmq_pkg.sv */
// Shared types and codes for the coalescing message queue.
`timescale 1ns / 1ps

package cmq_pkg;

    typedef enum logic [1:0] {
        OP_POST  = 2'd0,
        OP_GET   = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_REJECT   = 2'd1,
        STS_DISABLED = 2'd2,
        STS_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EXEC  = 2'd2
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic exec;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_stat;

endpackage

/* design/cmq_if.sv */
// Request and response channel interfaces for the coalescing message queue.
`timescale 1ns / 1ps

interface cmq_req_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  opcode;
    logic               unique_only;
    logic signed [15:0] message_id;
    logic signed [31:0] param_first;
    logic signed [31:0] param_second;

    modport source (
        output valid, opcode, unique_only, message_id, param_first, param_second,
        input  ready
    );
    modport sink (
        input  valid, opcode, unique_only, message_id, param_first, param_second,
        output ready
    );
endinterface

interface cmq_rsp_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic signed [15:0] out_message_id;
    logic signed [31:0] out_param_first;
    logic signed [31:0] out_param_second;
    logic        [7:0]  queue_length;
    logic        [31:0] full_drop_count;

    modport source (
        output valid, status, out_message_id, out_param_first, out_param_second,
               queue_length, full_drop_count,
        input  ready
    );
    modport sink (
        input  valid, status, out_message_id, out_param_first, out_param_second,
               queue_length, full_drop_count,
        output ready
    );
endinterface

/* design/cmq_ctrl.sv */
// Controller state machine: mark clearing sweep, request accept and commit.
`timescale 1ns / 1ps

module cmq_ctrl import cmq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.clr_step = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.exec     = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_EXEC: begin
                // Hold the commit until the output register is free.
                o_cmd.exec = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* design/cmq_datapath.sv */
// Datapath: queue memories, pending mark memory, pointers and result register.
`timescale 1ns / 1ps

module cmq_datapath import cmq_pkg::*; #(
    parameter int QUEUE_DEPTH = 128,
    parameter int ID_SET_SIZE = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic        [1:0]  i_opcode,
    input  logic               i_unique_only,
    input  logic signed [15:0] i_message_id,
    input  logic signed [31:0] i_param_first,
    input  logic signed [31:0] i_param_second,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic        [1:0]  o_status,
    output logic signed [15:0] o_out_message_id,
    output logic signed [31:0] o_out_param_first,
    output logic signed [31:0] o_out_param_second,
    output logic        [7:0]  o_queue_length,
    output logic        [31:0] o_full_drop_count
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW = (ID_SET_SIZE > 1) ? $clog2(ID_SET_SIZE) : 1;

    // Memories
    logic [15:0] mem_id     [QUEUE_DEPTH];
    logic [31:0] mem_first  [QUEUE_DEPTH];
    logic [31:0] mem_second [QUEUE_DEPTH];
    logic        mem_mark   [ID_SET_SIZE];

    // Control state
    logic          r_enable;
    logic [QW-1:0] r_rd_slot, n_rd_slot;
    logic [QW-1:0] r_wr_slot;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]   r_drop, n_drop;
    logic [MW-1:0] r_clr_addr;
    logic          r_out_valid;

    // Latched request and registered read data
    logic [1:0]  r_op;
    logic        r_unique;
    logic [15:0] r_id;
    logic [31:0] r_w1, r_w2;
    logic        r_tracked;
    logic [MW-1:0] r_slot;
    logic        r_mark_q;
    logic [15:0] r_qid_q;
    logic [31:0] r_qw1_q, r_qw2_q;

    // Result register
    logic [1:0]  r_status;
    logic [15:0] r_out_id;
    logic [31:0] r_out_w1, r_out_w2;
    logic [7:0]  r_len;

    logic          in_tracked;
    logic [MW-1:0] in_slot;
    logic          q_tracked;
    logic          q_push, q_pop, q_flush;
    logic          mark_we, mark_wd;
    logic [MW-1:0] mark_wa;
    logic [1:0]    n_status;
    logic [15:0]   n_out_id;
    logic [31:0]   n_out_w1, n_out_w2;

    assign in_tracked = !i_message_id[15] && ($unsigned(i_message_id) < 16'(ID_SET_SIZE));
    assign in_slot    = i_message_id[MW-1:0];
    assign q_tracked  = !r_qid_q[15] && (r_qid_q < 16'(ID_SET_SIZE));

    assign o_stat.clr_last = (r_clr_addr == MW'(ID_SET_SIZE - 1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // Decide the effect of the latched request.
    always_comb begin
        q_push   = 1'b0;
        q_pop    = 1'b0;
        q_flush  = 1'b0;
        n_status = STS_OK;
        n_drop   = r_drop;
        n_out_id = '0;
        n_out_w1 = '0;
        n_out_w2 = '0;
        case (r_op)
            OP_POST: begin
                if (!r_enable) begin
                    n_status = STS_DISABLED;
                end else if (r_unique && r_tracked && r_mark_q) begin
                    n_status = STS_REJECT;
                end else if (r_count == CW'(QUEUE_DEPTH)) begin
                    n_status = STS_REJECT;
                    n_drop   = r_drop + 32'd1;
                end else begin
                    q_push = 1'b1;
                end
            end
            OP_GET: begin
                if (r_count == '0) begin
                    n_status = STS_EMPTY;
                end else begin
                    q_pop    = 1'b1;
                    n_out_id = r_qid_q;
                    n_out_w1 = r_qw1_q;
                    n_out_w2 = r_qw2_q;
                end
            end
            OP_CLEAR: q_flush = 1'b1;
            default:  n_status = STS_OK;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_rd_slot = r_rd_slot;
        if (q_flush) begin
            n_count = '0;
        end else if (q_push) begin
            n_count = r_count + 1'b1;
        end else if (q_pop) begin
            n_count   = r_count - 1'b1;
            n_rd_slot = (r_rd_slot == QW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_slot + 1'b1;
        end
    end

    // Mark write port: zero sweep after reset, set on push, clear on pop.
    always_comb begin
        mark_we = 1'b0;
        mark_wa = r_slot;
        mark_wd = 1'b0;
        if (i_cmd.clr_step) begin
            mark_we = 1'b1;
            mark_wa = r_clr_addr;
        end else if (i_cmd.exec && q_push && r_tracked) begin
            mark_we = 1'b1;
            mark_wd = 1'b1;
        end else if (i_cmd.exec && q_pop && q_tracked) begin
            mark_we = 1'b1;
            mark_wa = r_qid_q[MW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) mem_mark[mark_wa] <= mark_wd;
        if (i_cmd.accept) r_mark_q <= mem_mark[in_slot];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && q_push) begin
            mem_id[r_wr_slot]     <= r_id;
            mem_first[r_wr_slot]  <= r_w1;
            mem_second[r_wr_slot] <= r_w2;
        end
        if (i_cmd.accept) begin
            r_qid_q <= mem_id[r_rd_slot];
            r_qw1_q <= mem_first[r_rd_slot];
            r_qw2_q <= mem_second[r_rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op      <= i_opcode;
            r_unique  <= i_unique_only;
            r_id      <= i_message_id;
            r_w1      <= i_param_first;
            r_w2      <= i_param_second;
            r_tracked <= in_tracked;
            r_slot    <= in_slot;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_out_id <= n_out_id;
            r_out_w1 <= n_out_w1;
            r_out_w2 <= n_out_w2;
            r_len    <= 8'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_rd_slot   <= '0;
            r_wr_slot   <= '0;
            r_count     <= '0;
            r_drop      <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_enable <= i_cfg_wdata;
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.exec) begin
                r_count   <= n_count;
                r_rd_slot <= q_flush ? '0 : n_rd_slot;
                r_drop    <= n_drop;
                if (q_flush) begin
                    r_wr_slot <= '0;
                end else if (q_push) begin
                    r_wr_slot <= (r_wr_slot == QW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_slot + 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_out_message_id   = r_out_id;
    assign o_out_param_first  = r_out_w1;
    assign o_out_param_second = r_out_w2;
    assign o_queue_length     = r_len;
    assign o_full_drop_count  = r_drop;

endmodule

/* design/coalescing_message_queue.sv */
// Top level of the coalescing message queue: controller plus datapath.
//
//  channel   dir  handshake         payload
//  i_req     in   valid / ready     opcode, unique_only, message_id, param_first/second
//  o_rsp     out  valid / ready     status, out_message_id, out_param_first/second,
//                                   queue_length, full_drop_count
//  i_cfg_*   in   write enable      queue_enable (one bit)
//
// Each transaction is accepted, then committed: the accept latches the request and reads the
// queue and pending mark memories, the commit decides and writes back. The shared
// read-modify-write on those memories keeps a new request out until the commit.
// After reset the pending mark memory is swept to zero, one entry a cycle,
// over all ID_SET_SIZE entries; no request is taken meanwhile.
// The result sits in an output register; a new request is taken while it
// waits, and the commit stalls only if the previous result is still unread.
`timescale 1ns / 1ps

module coalescing_message_queue import cmq_pkg::*; #(
    parameter int QUEUE_DEPTH = 128,
    parameter int ID_SET_SIZE = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    cmq_req_if.sink   i_req,
    cmq_rsp_if.source o_rsp
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    // Sequence the sweep after reset, then each transaction: accept, commit.
    cmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    assign i_req.ready = in_ready;

    // Hold the storage, pointers, counters and the result register.
    cmq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_SET_SIZE (ID_SET_SIZE)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_opcode           (i_req.opcode),
        .i_unique_only      (i_req.unique_only),
        .i_message_id       (i_req.message_id),
        .i_param_first      (i_req.param_first),
        .i_param_second     (i_req.param_second),
        .i_out_ready        (o_rsp.ready),
        .o_out_valid        (o_rsp.valid),
        .o_status           (o_rsp.status),
        .o_out_message_id   (o_rsp.out_message_id),
        .o_out_param_first  (o_rsp.out_param_first),
        .o_out_param_second (o_rsp.out_param_second),
        .o_queue_length     (o_rsp.queue_length),
        .o_full_drop_count  (o_rsp.full_drop_count)
    );

endmodule

/* verif/cmq_response_checker.sv */
// Checker that predicts and compares every response of the coalescing message queue.
`timescale 1ns / 1ps

module cmq_response_checker import cmq_pkg::*; #(
    parameter int QUEUE_DEPTH = 128,
    parameter int ID_SET_SIZE = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    cmq_req_if        i_req,
    cmq_rsp_if        i_rsp,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked
);

    localparam int PTR_SPAN = 2 * QUEUE_DEPTH;

    typedef struct packed {
        t_status     status;
        logic [15:0] msg_id;
        logic [31:0] first_word;
        logic [31:0] second_word;
        logic [7:0]  length;
        logic [31:0] drops;
    } t_queue_response;

    logic        queue_enable;
    logic [15:0] slot_ids     [QUEUE_DEPTH];
    logic [31:0] slot_first   [QUEUE_DEPTH];
    logic [31:0] slot_second  [QUEUE_DEPTH];
    logic        id_pending   [ID_SET_SIZE];
    int          read_ptr;
    int          write_ptr;
    logic [31:0] full_drops;

    t_queue_response awaited_responses[$];

    function automatic int held_entries();
        return (write_ptr + PTR_SPAN - read_ptr) % PTR_SPAN;
    endfunction

    function automatic bit id_is_tracked(input logic [15:0] id);
        return (id[15] == 1'b0) && (int'(id) < ID_SET_SIZE);
    endfunction

    // Apply one request to the shadow queue and return the response it earns.
    function automatic t_queue_response advance_queue_model(
        input logic [1:0]  op,
        input logic        uniq,
        input logic [15:0] id,
        input logic [31:0] w1,
        input logic [31:0] w2
    );
        t_queue_response resp;
        int              slot;
        resp        = '0;
        resp.status = STS_OK;
        case (op)
            OP_POST: begin
                if (!queue_enable) begin
                    resp.status = STS_DISABLED;
                end else if (uniq && id_is_tracked(id) && id_pending[int'(id)]) begin
                    resp.status = STS_REJECT;
                end else if (held_entries() >= QUEUE_DEPTH) begin
                    full_drops  = full_drops + 32'd1;
                    resp.status = STS_REJECT;
                end else begin
                    slot              = write_ptr % QUEUE_DEPTH;
                    slot_ids[slot]    = id;
                    slot_first[slot]  = w1;
                    slot_second[slot] = w2;
                    if (id_is_tracked(id)) begin
                        id_pending[int'(id)] = 1'b1;
                    end
                    write_ptr = (write_ptr + 1) % PTR_SPAN;
                end
            end
            OP_GET: begin
                if (held_entries() == 0) begin
                    resp.status = STS_EMPTY;
                end else begin
                    slot             = read_ptr % QUEUE_DEPTH;
                    resp.msg_id      = slot_ids[slot];
                    resp.first_word  = slot_first[slot];
                    resp.second_word = slot_second[slot];
                    if (id_is_tracked(slot_ids[slot])) begin
                        id_pending[int'(slot_ids[slot])] = 1'b0;
                    end
                    read_ptr = (read_ptr + 1) % PTR_SPAN;
                end
            end
            OP_CLEAR: begin
                read_ptr  = 0;
                write_ptr = 0;
            end
            default: begin
            end
        endcase
        resp.length = 8'(held_entries());
        resp.drops  = full_drops;
        return resp;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_queue_response want;
        if (!i_rst_n) begin
            queue_enable = 1'b0;
            read_ptr     = 0;
            write_ptr    = 0;
            full_drops   = '0;
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                slot_ids[i]    = '0;
                slot_first[i]  = '0;
                slot_second[i] = '0;
            end
            for (int i = 0; i < ID_SET_SIZE; i++) begin
                id_pending[i] = 1'b0;
            end
            awaited_responses.delete();
        end else begin
            if (i_cfg_we) begin
                queue_enable = i_cfg_wdata;
            end
            // Retire the oldest expectation before queuing a new one.
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_responses.size() == 0) begin
                    $error("response: expected none, actual status %0d", i_rsp.status);
                    o_fail_count++;
                end else begin
                    want = awaited_responses.pop_front();
                    check_field("status", want.status, i_rsp.status);
                    check_field("out_message_id", want.msg_id,
                                $unsigned(i_rsp.out_message_id));
                    check_field("out_param_first", want.first_word,
                                i_rsp.out_param_first);
                    check_field("out_param_second", want.second_word,
                                i_rsp.out_param_second);
                    check_field("queue_length", want.length, i_rsp.queue_length);
                    check_field("full_drop_count", want.drops, i_rsp.full_drop_count);
                    o_checked++;
                end
            end
            if (i_req.valid && i_req.ready) begin
                awaited_responses.push_back(advance_queue_model(
                    i_req.opcode, i_req.unique_only, i_req.message_id,
                    i_req.param_first, i_req.param_second));
            end
        end
        o_pending = awaited_responses.size();
    end

endmodule

/* verif/coalescing_message_queue_tb.sv */
// Testbench top for the coalescing message queue: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module coalescing_message_queue_tb;
    import cmq_pkg::*;

    localparam int QUEUE_DEPTH   = 128;
    localparam int ID_SET_SIZE   = 128;
    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 11;
    // Accept and commit for each transaction plus the output register; leave some slack.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    // Longest quiet stretch is the mark sweep after reset, over all ID_SET_SIZE
    // entries; receiver stalls and sender gaps are shorter.
    localparam int STALL_LIMIT   = 2000;
    // Opcode three has no package name; the block must ignore it.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        unique_only;
        logic [15:0] message_id;
        logic [31:0] param_first;
        logic [31:0] param_second;
    } t_request;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cfg_we    = 1'b0;
    logic cfg_wdata = 1'b0;

    int fail_count;
    int pending;
    int checked;

    int posts_sent;
    int gets_sent;
    int clears_sent;
    int unused_sent;
    int enable_writes;

    cmq_req_if req_ch ();
    cmq_rsp_if rsp_ch ();

    coalescing_message_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_SET_SIZE (ID_SET_SIZE)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    cmq_response_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_SET_SIZE (ID_SET_SIZE)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------

    function automatic t_request make_request(input logic [1:0] op, input logic uniq,
                                              input logic [15:0] id,
                                              input logic [31:0] w1,
                                              input logic [31:0] w2);
        t_request r;
        r.opcode       = op;
        r.unique_only  = uniq;
        r.message_id   = id;
        r.param_first  = w1;
        r.param_second = w2;
        return r;
    endfunction

    // Mostly full-range words, with zero, the signed extremes and all-ones mixed in.
    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Pick an id: a narrow pool makes duplicates frequent; otherwise spread
    // over the tracked set, its upper boundary, negatives and the full range.
    function automatic logic [15:0] random_id(input bit narrow);
        int pick;
        pick = $urandom_range(0, 9);
        if (narrow && pick < 7) begin
            return 16'($urandom_range(0, 7));
        end
        case (pick)
            0, 1, 2, 3, 4: return 16'($urandom_range(0, ID_SET_SIZE - 1));
            5:             return 16'($urandom_range(ID_SET_SIZE - 2, ID_SET_SIZE + 1));
            6, 7:          return 16'h8000 | 16'($urandom);
            default:       return 16'($urandom);
        endcase
    endfunction

    // The opcode mix is given in percent; whatever post and get leave over goes
    // to clear, except one slot in a hundred that sends the unused opcode.
    function automatic t_request random_request(input int post_pct, input int get_pct,
                                                input int unique_pct, input bit narrow);
        t_request r;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < post_pct) begin
            r.opcode = OP_POST;
        end else if (roll < post_pct + get_pct) begin
            r.opcode = OP_GET;
        end else if (roll == 99) begin
            r.opcode = OP_UNUSED;
        end else begin
            r.opcode = OP_CLEAR;
        end
        r.unique_only  = ($urandom_range(0, 99) < unique_pct);
        r.message_id   = random_id(narrow);
        r.param_first  = random_word();
        r.param_second = random_word();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------

    // Present one transaction at the falling edge and hold it until the block
    // takes it. Valid stays high, so back-to-back calls form a burst.
    task automatic send_request(input t_request r);
        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= r.opcode;
        req_ch.unique_only  <= r.unique_only;
        req_ch.message_id   <= r.message_id;
        req_ch.param_first  <= r.param_first;
        req_ch.param_second <= r.param_second;
        @(posedge clk);
        while (!req_ch.ready) begin
            @(posedge clk);
        end
        case (r.opcode)
            OP_POST:  posts_sent++;
            OP_GET:   gets_sent++;
            OP_CLEAR: clears_sent++;
            default:  unused_sent++;
        endcase
    endtask

    // Drop valid for a gap of the given number of cycles (at least one).
    task automatic pause_sender(input int cycles);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Write the enable register only once the block has nothing in flight:
    // drop valid, wait for every response, then let the pipeline settle.
    task automatic set_queue_enable(input logic value);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        enable_writes++;
    endtask

    // Random traffic in bursts of 1..40 transactions; most bursts are preceded
    // by a gap with valid low, the rest run straight on from the last one.
    task automatic run_random(input int count, input int post_pct, input int get_pct,
                              input int unique_pct, input bit narrow);
        int burst_left;
        burst_left = 0;
        repeat (count) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0) begin
                    pause_sender($urandom_range(1, 12));
                end
            end
            send_request(random_request(post_pct, get_pct, unique_pct, narrow));
            burst_left--;
        end
    endtask

    // ------------------------------------------------------------------
    // Response stall pattern
    // ------------------------------------------------------------------

    // Switch among modes picked at random: always ready, coin flip, one cycle in
    // four, or alternating ready and stalled runs.
    initial begin : rsp_stall
        int   cycle;
        int   mode;
        int   run_left;
        logic run_level;
        logic rdy;
        cycle     = 0;
        mode      = 0;
        run_left  = 0;
        run_level = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (cycle % 256 == 0) begin
                mode = $urandom_range(0, 3);
            end
            case (mode)
                0: rdy = 1'b1;
                1: rdy = 1'($urandom_range(0, 1));
                2: rdy = (cycle % 4 == 0);
                default: begin
                    if (run_left == 0) begin
                        run_left  = $urandom_range(1, 24);
                        run_level = ~run_level;
                    end
                    run_left--;
                    rdy = run_level;
                end
            endcase
            rsp_ch.ready <= rdy;
            cycle++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count the clock edges at which no transaction moves on either channel,
    // restart the count at every handshake, and end the run once it reaches STALL_LIMIT.
    // ------------------------------------------------------------------

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Timeout: no transaction for %0d cycles, %0d responses outstanding",
                 STALL_LIMIT, pending);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        posts_sent    = 0;
        gets_sent     = 0;
        clears_sent   = 0;
        unused_sent   = 0;
        enable_writes = 0;

        req_ch.valid        <= 1'b0;
        req_ch.opcode       <= OP_POST;
        req_ch.unique_only  <= 1'b0;
        req_ch.message_id   <= '0;
        req_ch.param_first  <= '0;
        req_ch.param_second <= '0;

        // Hold reset for the first cycles; the block then sweeps its marks and
        // holds ready low until that is done, which the handshake absorbs.
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Enable is off out of reset: posts bounce, get and clear still run,
        // and the unused opcode does nothing.
        send_request(make_request(OP_POST,   1'b0, 16'd5, 32'h1234_5678, 32'h9ABC_DEF0));
        send_request(make_request(OP_GET,    1'b0, 16'd0, 32'h0, 32'h0));
        send_request(make_request(OP_CLEAR,  1'b0, 16'd0, 32'h0, 32'h0));
        send_request(make_request(OP_UNUSED, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

        set_queue_enable(1'b1);

        // Lowest tracked id, then its duplicate; top of the tracked set.
        send_request(make_request(OP_POST, 1'b0, 16'd0, 32'h8000_0000, 32'h7FFF_FFFF));
        send_request(make_request(OP_POST, 1'b1, 16'd0, 32'h0000_0001, 32'h0000_0002));
        send_request(make_request(OP_POST, 1'b1, 16'(ID_SET_SIZE - 1),
                                  32'hFFFF_FFFF, 32'h0000_0000));
        // Ids past the set and negative ids queue every time, unique or not.
        send_request(make_request(OP_POST, 1'b1, 16'(ID_SET_SIZE), 32'h0, 32'hFFFF_FFFF));
        send_request(make_request(OP_POST, 1'b1, 16'(ID_SET_SIZE), 32'h1, 32'h1));
        send_request(make_request(OP_POST, 1'b1, 16'hFFFF, 32'h5555_5555, 32'hAAAA_AAAA));
        send_request(make_request(OP_POST, 1'b1, 16'h8000, 32'hAAAA_AAAA, 32'h5555_5555));
        send_request(make_request(OP_POST, 1'b1, 16'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000));
        // Taking the first entry frees id 0 for a unique post again.
        send_request(make_request(OP_GET,  1'b0, 16'd0, 32'h0, 32'h0));
        send_request(make_request(OP_POST, 1'b1, 16'd0, 32'hDEAD_BEEF, 32'hCAFE_F00D));
        send_request(make_request(OP_UNUSED, 1'b0, 16'd0, 32'h0, 32'h0));
        // Clear keeps the marks: a unique post of the top id still bounces.
        send_request(make_request(OP_CLEAR, 1'b0, 16'd0, 32'h0, 32'h0));
        send_request(make_request(OP_POST, 1'b1, 16'(ID_SET_SIZE - 1), 32'h3, 32'h4));
        send_request(make_request(OP_GET,  1'b0, 16'd0, 32'h0, 32'h0));
        // A plain post and a get release that mark.
        send_request(make_request(OP_POST, 1'b0, 16'(ID_SET_SIZE - 1), 32'h5, 32'h6));
        send_request(make_request(OP_GET,  1'b0, 16'd0, 32'h0, 32'h0));
        send_request(make_request(OP_POST, 1'b1, 16'(ID_SET_SIZE - 1), 32'h7, 32'h8));

        // Disabled again: a duplicate reports disabled, get and clear still work.
        set_queue_enable(1'b0);
        send_request(make_request(OP_POST,  1'b1, 16'(ID_SET_SIZE - 1), 32'h9, 32'hA));
        send_request(make_request(OP_GET,   1'b0, 16'd0, 32'h0, 32'h0));
        send_request(make_request(OP_CLEAR, 1'b0, 16'd0, 32'h0, 32'h0));
        send_request(make_request(OP_GET,   1'b0, 16'd0, 32'h0, 32'h0));

        // Balanced traffic, then a post-heavy stretch that fills the queue and
        // drives the drop counter.
        set_queue_enable(1'b1);
        run_random(300, 50, 42, 30, 1'b0);
        run_random(250, 92, 7, 10, 1'b0);

        // Disabled: posts bounce while gets drain what is left.
        set_queue_enable(1'b0);
        run_random(100, 40, 50, 30, 1'b0);

        // Narrow id pool with many unique posts to exercise suppression.
        set_queue_enable(1'b1);
        run_random(350, 45, 40, 60, 1'b1);

        // Drain: drop valid, wait for the last response, then keep watching for anything
        // unexpected before the verdict.
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d posts, %0d gets, %0d clears, %0d unused opcodes, %0d enable writes",
                 posts_sent, gets_sent, clears_sent, unused_sent, enable_writes);
        $display("Compared %0d responses field by field, %0d failures",
                 checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
design/cmq_pkg.sv
design/cmq_if.sv
design/cmq_ctrl.sv
design/cmq_datapath.sv
design/coalescing_message_queue.sv
verif/cmq_response_checker.sv
verif/coalescing_message_queue_tb.sv
